>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define BPE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Expression must never be true outside reset.
`define BPE_NEVER(lbl, clk, rst_n, expr) \
	`BPE_ASSERT(lbl, clk, rst_n, !(expr))
`else
`define BPE_ASSERT(lbl, clk, rst_n, prop)
`define BPE_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

>>> hw/rtl/bpe_pkg.sv
// Types, constants and command structs of the Bezier point evaluator.
package bpe_pkg;

	localparam int MAX_POINTS = 16;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	localparam int COORD_W = 32;
	localparam int IDX_W   = 4;
	localparam int T_W     = 17;
	localparam int NUM_W   = 5;
	localparam int FRAC_W  = 16;

	localparam logic [T_W-1:0] T_ONE = T_W'(1 << FRAC_W);

	// cycles from read issue until the interpolated word is readable
	localparam int WR_LAT    = 4;
	localparam int DRAIN_CYC = WR_LAT - 1;
	localparam int DRAIN_W   = $clog2(DRAIN_CYC + 1);

	typedef enum logic [0:0] {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_POINTS = 2'd1,
		ST_T_RANGE   = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		SRC_CTRL = 1'b0,
		SRC_WORK = 1'b1
	} src_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PASS,
		S_DRAIN,
		S_WAIT_FIN,
		S_FIN,
		S_ERR
	} state_t;

	typedef struct packed {
		logic              load_we;
		logic              t_load;
		logic              rd_en;
		src_t              rd_src;
		logic              rd_first;
		logic              rd_res;
		logic [ADDR_W-1:0] rd_addr;
		logic              err_load;
		status_t           err_status;
	} bpe_cmd_t;

	typedef struct packed {
		logic out_full;
	} bpe_sts_t;

endpackage

>>> hw/rtl/bpe_channels.sv
// Channel interfaces: point input, curve output, configuration write.
interface bpe_in_if import bpe_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      operation;
	logic [IDX_W-1:0]          point_index;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic [T_W-1:0]            param_t;

	modport source (output valid, operation, point_index, point_x, point_y, param_t,
		input ready);
	modport sink (input valid, operation, point_index, point_x, point_y, param_t,
		output ready);
endinterface

interface bpe_out_if import bpe_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] curve_x;
	logic signed [COORD_W-1:0] curve_y;
	logic [1:0]                status;

	modport source (output valid, curve_x, curve_y, status, input ready);
	modport sink (input valid, curve_x, curve_y, status, output ready);
endinterface

interface bpe_cfg_if import bpe_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [NUM_W-1:0] num_points;

	modport source (output valid, num_points, input ready);
	modport sink (input valid, num_points, output ready);
endinterface

>>> hw/rtl/bpe_ctrl.sv
// Sequencer: walks the interpolation passes and drives the datapath.
module bpe_ctrl import bpe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_op,
	input  logic [IDX_W-1:0] in_idx,
	input  logic [T_W-1:0]   in_t,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [NUM_W-1:0] cfg_num,
	input  bpe_sts_t         sts,
	output bpe_cmd_t         cmd
);

	state_t             state_q, state_d;
	logic [NUM_W-1:0]   num_q;
	logic [CNT_W-1:0]   len_q;
	logic [ADDR_W-1:0]  k_q;
	logic               first_pass_q;
	logic [DRAIN_W-1:0] drain_q;
	status_t            err_status_q;

	logic             accept;
	logic             is_eval;
	logic [CNT_W-1:0] n_eff;
	logic             last_k;
	logic             drain_done;

	assign in_ready   = (state_q == S_IDLE);
	assign cfg_ready  = 1'b1;
	assign accept     = in_valid && in_ready;
	assign is_eval    = (in_op == OP_EVAL);
	assign n_eff      = (int'(num_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(num_q);
	assign last_k     = (CNT_W'(k_q) == len_q - CNT_W'(1));
	assign drain_done = (drain_q == DRAIN_W'(DRAIN_CYC - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			num_q <= cfg_num;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q        <= '0;
			k_q          <= '0;
			first_pass_q <= 1'b0;
			drain_q      <= '0;
			err_status_q <= ST_OK;
		end else begin
			drain_q <= (state_q == S_DRAIN) ? drain_q + DRAIN_W'(1) : '0;
			if (state_q == S_IDLE && accept && is_eval) begin
				len_q        <= n_eff;
				k_q          <= '0;
				first_pass_q <= 1'b1;
				err_status_q <= (n_eff == '0) ? ST_NO_POINTS : ST_T_RANGE;
			end else if (state_q == S_PASS) begin
				if (last_k) begin
					k_q          <= '0;
					len_q        <= len_q - CNT_W'(1);
					first_pass_q <= 1'b0;
				end else begin
					k_q <= k_q + ADDR_W'(1);
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && is_eval) begin
					if (n_eff == '0 || in_t > T_ONE)
						state_d = S_ERR;
					else if (n_eff == CNT_W'(1))
						state_d = S_WAIT_FIN;
					else
						state_d = S_PASS;
				end
			end
			S_PASS: begin
				// long passes finish their writes before the next pass reads them
				if (last_k)
					state_d = (int'(len_q) >= WR_LAT + 1) ? S_PASS : S_DRAIN;
			end
			S_DRAIN: begin
				if (drain_done)
					state_d = (len_q > CNT_W'(1)) ? S_PASS : S_WAIT_FIN;
			end
			S_WAIT_FIN: begin
				if (!sts.out_full)
					state_d = S_FIN;
			end
			S_FIN: begin
				state_d = S_IDLE;
			end
			S_ERR: begin
				if (!sts.out_full)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.rd_src     = first_pass_q ? SRC_CTRL : SRC_WORK;
		cmd.rd_addr    = k_q;
		cmd.err_status = err_status_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.t_load  = accept;
				cmd.load_we = accept && !is_eval && (int'(in_idx) < MAX_POINTS);
			end
			S_PASS: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_first = (k_q == '0);
			end
			S_FIN: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_res = 1'b1;
			end
			S_ERR: begin
				cmd.err_load = !sts.out_full;
			end
			S_DRAIN, S_WAIT_FIN: begin
			end
			default: begin
			end
		endcase
	end

endmodule

>>> hw/rtl/bpe_datapath.sv
// Point stores, interpolation pipeline and result register.
`include "assert_macros.svh"

module bpe_datapath import bpe_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bpe_cmd_t                  cmd,
	output bpe_sts_t                  sts,
	input  logic [IDX_W-1:0]          in_idx,
	input  logic signed [COORD_W-1:0] in_x,
	input  logic signed [COORD_W-1:0] in_y,
	input  logic [T_W-1:0]            in_t,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] out_x,
	output logic signed [COORD_W-1:0] out_y,
	output status_t                   out_status
);

	localparam int PROD_W = COORD_W + T_W + 2;

	logic [COORD_W-1:0] ctrl_x_mem [MAX_POINTS];
	logic [COORD_W-1:0] ctrl_y_mem [MAX_POINTS];
	logic [COORD_W-1:0] work_x_mem [MAX_POINTS];
	logic [COORD_W-1:0] work_y_mem [MAX_POINTS];

	logic [T_W-1:0] t_q;

	// stage 1: read data and tags
	logic [COORD_W-1:0] cx_s1, cy_s1, wx_s1, wy_s1;
	logic               vld_s1, first_s1, res_s1;
	src_t               src_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [COORD_W-1:0] bx, by;
	logic [COORD_W-1:0] prev_x_q, prev_y_q;

	// stage 2: difference
	logic signed [COORD_W:0] dx_s2, dy_s2;
	logic [COORD_W-1:0]      ax_s2, ay_s2;
	logic                    vld_s2;
	logic [ADDR_W-1:0]       addr_s2;

	// stage 3: product
	logic signed [PROD_W-1:0] px_s3, py_s3;
	logic [COORD_W-1:0]       ax_s3, ay_s3;
	logic                     vld_s3;
	logic [ADDR_W-1:0]        addr_s3;

	logic signed [T_W:0] t_ext;

	logic full_q;

	assign t_ext = signed'({1'b0, t_q});

	always_ff @(posedge clk) begin
		if (cmd.t_load)
			t_q <= in_t;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_we) begin
			ctrl_x_mem[ADDR_W'(in_idx)] <= in_x;
			ctrl_y_mem[ADDR_W'(in_idx)] <= in_y;
		end
		if (cmd.rd_en) begin
			cx_s1 <= ctrl_x_mem[cmd.rd_addr];
			cy_s1 <= ctrl_y_mem[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			// a + floor(t * (b - a) / 2^16), wrapped to the coordinate width
			work_x_mem[addr_s3] <= ax_s3 + px_s3[FRAC_W +: COORD_W];
			work_y_mem[addr_s3] <= ay_s3 + py_s3[FRAC_W +: COORD_W];
		end
		if (cmd.rd_en) begin
			wx_s1 <= work_x_mem[cmd.rd_addr];
			wy_s1 <= work_y_mem[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
			res_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
		end else begin
			vld_s1   <= cmd.rd_en && !cmd.rd_res;
			first_s1 <= cmd.rd_first;
			res_s1   <= cmd.rd_en && cmd.rd_res;
			vld_s2   <= vld_s1 && !first_s1;
			vld_s3   <= vld_s2;
		end
	end

	assign bx = (src_s1 == SRC_CTRL) ? cx_s1 : wx_s1;
	assign by = (src_s1 == SRC_CTRL) ? cy_s1 : wy_s1;

	always_ff @(posedge clk) begin
		src_s1  <= cmd.rd_src;
		addr_s1 <= cmd.rd_addr;
		if (vld_s1) begin
			prev_x_q <= bx;
			prev_y_q <= by;
		end
		dx_s2   <= signed'({bx[COORD_W-1], bx}) - signed'({prev_x_q[COORD_W-1], prev_x_q});
		dy_s2   <= signed'({by[COORD_W-1], by}) - signed'({prev_y_q[COORD_W-1], prev_y_q});
		ax_s2   <= prev_x_q;
		ay_s2   <= prev_y_q;
		addr_s2 <= addr_s1 - ADDR_W'(1);
		px_s3   <= PROD_W'(dx_s2 * t_ext);
		py_s3   <= PROD_W'(dy_s2 * t_ext);
		ax_s3   <= ax_s2;
		ay_s3   <= ay_s2;
		addr_s3 <= addr_s2;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (res_s1 || cmd.err_load) begin
			full_q <= 1'b1;
		end else if (out_valid && out_ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_s1) begin
			out_x      <= bx;
			out_y      <= by;
			out_status <= ST_OK;
		end else if (cmd.err_load) begin
			out_x      <= '0;
			out_y      <= '0;
			out_status <= cmd.err_status;
		end
	end

	assign out_valid    = full_q;
	assign sts.out_full = full_q;

	`BPE_NEVER(a_res_overwrite, clk, arst_n, res_s1 && full_q)
	`BPE_NEVER(a_two_results, clk, arst_n, res_s1 && cmd.err_load)
	`BPE_ASSERT(a_full_source, clk, arst_n, $rose(full_q) |-> $past(res_s1 || cmd.err_load))

endmodule

>>> hw/rtl/bezier_point_evaluator_core.sv
// Top level of the Bezier point evaluator: channels, sequencer and datapath.
// Evaluates a Bezier curve of up to MAX_POINTS (16) signed Q15.16 control
// points at an unsigned Q1.16 parameter t by de Casteljau's repeated linear
// interpolation, a + ((t*(b-a)) >>> 16). A load beat writes one point to the
// store and gives no result; an evaluate beat gives one result beat. Every
// interpolation pass streams its points one per cycle, the first pass out of
// the control store and the later ones out of the single-read work store,
// through the shared x/y multiplier pair, and passes of four points or fewer
// wait out the read-to-write loop of the pipeline in a drain state. Errors
// (no points in use, t above 1.0) answer with zero coordinates. A finished
// result sits in an output register, so the next beat is taken while it
// waits. num_points must be written on the cfg channel only while the block
// is idle; the block itself does not enforce this. A count above 16 is
// treated as 16. Points must be loaded before an evaluation reads them.
module bezier_point_evaluator_core import bpe_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	bpe_in_if.sink      point_in,
	bpe_out_if.source   curve_out,
	bpe_cfg_if.sink     cfg
);

	bpe_cmd_t cmd;
	bpe_sts_t sts;
	status_t  out_status;

	// sequencer: accepts beats and walks the passes
	bpe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (point_in.valid),
		.in_ready  (point_in.ready),
		.in_op     (point_in.operation),
		.in_idx    (point_in.point_index),
		.in_t      (point_in.param_t),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.cfg_num   (cfg.num_points),
		.sts       (sts),
		.cmd       (cmd)
	);

	// stores, lerp pipeline and the result register
	bpe_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_idx     (point_in.point_index),
		.in_x       (point_in.point_x),
		.in_y       (point_in.point_y),
		.in_t       (point_in.param_t),
		.out_valid  (curve_out.valid),
		.out_ready  (curve_out.ready),
		.out_x      (curve_out.curve_x),
		.out_y      (curve_out.curve_y),
		.out_status (out_status)
	);

	assign curve_out.status = out_status;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for bezier_point_evaluator_core: scoreboard with curve predictor and random traffic.
module testbench import bpe_pkg::*; ();

	// Quiet cycles (no beat on any channel) before the run is declared hung.
	// The longest legal quiet stretch is the receiver hold plus one full
	// 16-point evaluation plus both idle gaps, well under this.
	localparam int QUIET_LIMIT   = 4000;
	// Loads write the store when they are taken, so a short settle is enough before a config write.
	localparam int IDLE_GAP      = 16;
	// Settle time after the last result, covers a full 16-point evaluation.
	localparam int DRAIN_CYCLES  = 200;
	// Receiver back-pressure: after this many results it holds off for a long stretch.
	localparam int PRESSURE_AT   = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_ITEMS   = 148;
	localparam logic [T_W-1:0] T_MAX = '1;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		status_t                   status;
	} curve_point_t;

	// Predicts curve results from the point store and point count, and checks
	// every result beat against the oldest pending prediction.
	class curve_scoreboard;
		logic [COORD_W-1:0] store_x [MAX_POINTS];
		logic [COORD_W-1:0] store_y [MAX_POINTS];
		logic [NUM_W-1:0]   points_in_use;
		curve_point_t       pending_curves [$];
		int                 errors;

		function new();
			points_in_use = '0;
			errors = 0;
		endfunction

		// One de Casteljau step: a + floor(t * (b - a) / 2^16), wrapped to 32 bits.
		function automatic logic [COORD_W-1:0] blend(logic signed [COORD_W-1:0] a,
			logic signed [COORD_W-1:0] b, logic [T_W-1:0] t);
			longint sa, diff, prod;
			sa   = longint'(a);
			diff = longint'(b) - sa;
			prod = diff * longint'(t);
			return COORD_W'(sa + (prod >>> FRAC_W));
		endfunction

		function automatic void note_point_beat(op_t op, logic [IDX_W-1:0] idx,
			logic [COORD_W-1:0] px, logic [COORD_W-1:0] py, logic [T_W-1:0] t);
			logic [COORD_W-1:0] wx [MAX_POINTS];
			logic [COORD_W-1:0] wy [MAX_POINTS];
			curve_point_t       res;
			int                 n;
			if (op == OP_LOAD) begin
				store_x[idx] = px;
				store_y[idx] = py;
				return;
			end
			res.x = '0;
			res.y = '0;
			n = (points_in_use > MAX_POINTS) ? MAX_POINTS : int'(points_in_use);
			if (n == 0) begin
				res.status = ST_NO_POINTS;
			end else if (t > T_ONE) begin
				res.status = ST_T_RANGE;
			end else begin
				wx = store_x;
				wy = store_y;
				for (int len = n; len > 1; len--) begin
					for (int i = 0; i < len - 1; i++) begin
						wx[i] = blend(wx[i], wx[i + 1], t);
						wy[i] = blend(wy[i], wy[i + 1], t);
					end
				end
				res.x = wx[0];
				res.y = wy[0];
				res.status = ST_OK;
			end
			pending_curves.push_back(res);
		endfunction

		function automatic void check_curve_beat(logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic [1:0] status);
			curve_point_t want;
			if (pending_curves.size() == 0) begin
				errors++;
				$display("%0t: unexpected curve beat x=%h y=%h status=%0d",
					$time, x, y, status);
				return;
			end
			want = pending_curves.pop_front();
			if (x !== want.x || y !== want.y || status !== want.status) begin
				errors++;
				$display("%0t: curve mismatch: expected x=%h y=%h status=%0d,",
					$time, want.x, want.y, want.status);
				$display("%0t:   actual x=%h y=%h status=%0d", $time, x, y, status);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bpe_in_if  point_if ();
	bpe_out_if curve_if ();
	bpe_cfg_if cfg_if ();

	curve_scoreboard sb = new();
	int beats_sent;

	bezier_point_evaluator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.point_in  (point_if),
		.curve_out (curve_if),
		.cfg       (cfg_if)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Idle gap for a side; every fifth block of 40 beats runs back to back.
	function automatic int idle_cycles(int seq);
		if ((seq / 40) % 5 == 2)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	// Coordinates lean on the extremes so the 33-bit difference path gets exercised.
	function automatic logic [COORD_W-1:0] pick_coord();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return 32'(signed'($urandom_range(0, 32'h3_ffff)) - 32'sh2_0000);
			default: return $urandom;
		endcase
	endfunction

	// Mostly legal t in [0, 1.0], with the ends and some out-of-range values.
	function automatic logic [T_W-1:0] pick_t();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return T_ONE;
			2: return T_W'($urandom_range(int'(T_ONE) + 1, int'(T_MAX)));
			default: return T_W'($urandom_range(0, int'(T_ONE)));
		endcase
	endfunction

	// Offer one point-channel beat and wait for it to be taken. valid stays
	// high into the next call when that call draws no gap.
	task automatic send_beat(op_t op, logic [IDX_W-1:0] idx, logic [COORD_W-1:0] px,
		logic [COORD_W-1:0] py, logic [T_W-1:0] t);
		int gap;
		gap = idle_cycles(beats_sent);
		if (gap > 0) begin
			point_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_if.valid       <= 1'b1;
		point_if.operation   <= op;
		point_if.point_index <= idx;
		point_if.point_x     <= px;
		point_if.point_y     <= py;
		point_if.param_t     <= t;
		do @(posedge clk); while (!point_if.ready);
		sb.note_point_beat(op, idx, px, py, t);
		beats_sent++;
	endtask

	// num_points only changes with the block idle: all results in, loads settled.
	task automatic set_point_count(logic [NUM_W-1:0] n);
		point_if.valid <= 1'b0;
		while (sb.pending_curves.size() != 0) @(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
		cfg_if.valid      <= 1'b1;
		cfg_if.num_points <= n;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		sb.points_in_use = n;
	endtask

	task automatic eval_at(logic [T_W-1:0] t);
		send_beat(OP_EVAL, IDX_W'($urandom), $urandom, $urandom, t);
	endtask

	// Random traffic: about a third loads that keep reshaping the curve, the
	// rest evaluations carrying junk load fields.
	task automatic random_phase(int items);
		for (int k = 0; k < items; k++) begin
			if ($urandom_range(0, 99) < 35)
				send_beat(OP_LOAD, IDX_W'($urandom_range(0, MAX_POINTS - 1)),
					pick_coord(), pick_coord(), T_W'($urandom));
			else
				send_beat(OP_EVAL, IDX_W'($urandom), $urandom, $urandom, pick_t());
		end
	endtask

	// Receiver: random ready gaps, plus one long hold so the output register
	// fills and the block has to stall its input.
	initial begin
		int gap;
		int taken;
		bit held;
		taken = 0;
		held = 1'b0;
		curve_if.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && taken == PRESSURE_AT) begin
				held = 1'b1;
				gap = HOLD_CYCLES;
			end else begin
				gap = idle_cycles(taken);
			end
			if (gap > 0) begin
				curve_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			curve_if.ready <= 1'b1;
			do @(posedge clk); while (!curve_if.valid);
			taken++;
		end
	end

	// Result monitor: samples at the edge, before this edge's updates land.
	always @(posedge clk) begin
		if (arst_n && curve_if.valid && curve_if.ready)
			sb.check_curve_beat(curve_if.curve_x, curve_if.curve_y, curve_if.status);
	end

	// Watchdog: any beat on any channel resets the quiet count.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (point_if.valid && point_if.ready)
					|| (curve_if.valid && curve_if.ready)
					|| (cfg_if.valid && cfg_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("bezier_point_evaluator_core test failed");
		$finish;
	end

	initial begin
		logic [NUM_W-1:0] phase_counts [13];
		phase_counts = '{5'd2, 5'd16, 5'd3, 5'd31, 5'd5, 5'd1, 5'd8, 5'd0, 5'd12,
			5'd4, 5'd20, 5'd7, 5'd16};
		beats_sent = 0;
		point_if.valid       <= 1'b0;
		point_if.operation   <= OP_LOAD;
		point_if.point_index <= '0;
		point_if.point_x     <= '0;
		point_if.point_y     <= '0;
		point_if.param_t     <= '0;
		cfg_if.valid         <= 1'b0;
		cfg_if.num_points    <= '0;
		arst_n               <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Count is zero out of reset: no-points status, and it wins over a bad t.
		eval_at('0);
		eval_at(T_MAX);

		// Fill the whole store before anything reads it; first slots hold the
		// extreme coordinates so neighbor differences span the full range.
		send_beat(OP_LOAD, 4'd0, 32'h8000_0000, 32'h7fff_ffff, T_MAX);
		send_beat(OP_LOAD, 4'd1, 32'h7fff_ffff, 32'h8000_0000, '0);
		send_beat(OP_LOAD, 4'd2, 32'h0000_0000, 32'hffff_ffff, T_ONE);
		send_beat(OP_LOAD, 4'd3, 32'h0001_0000, 32'hffff_0000, '0);
		for (int i = 4; i < MAX_POINTS; i++)
			send_beat(OP_LOAD, IDX_W'(i), $urandom, $urandom, T_W'($urandom));

		// Single point comes back unchanged; t just above one is rejected.
		set_point_count(5'd1);
		eval_at(T_W'(32768));
		eval_at(T_ONE + 1'b1);

		// Full degree-15 curve at both ends, mid-point and an out-of-range t.
		set_point_count(5'd16);
		eval_at('0);
		eval_at(T_ONE);
		eval_at(T_MAX);
		eval_at(T_W'(32768));

		// Count above the store size behaves as a full store.
		set_point_count(5'd31);
		eval_at(T_W'(12345));

		foreach (phase_counts[p]) begin
			set_point_count(phase_counts[p]);
			random_phase(PHASE_ITEMS);
		end

		point_if.valid <= 1'b0;
		while (sb.pending_curves.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_curves.size() == 0)
			$display("bezier_point_evaluator_core test passed");
		else
			$display("bezier_point_evaluator_core test failed");
		$finish;
	end

endmodule
